@@ src/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared widths, register indexes and word types for the vertex transform.
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int COORD_W = 32;
	localparam int ENTRY_W = 16;
	localparam int COORD_F = COORD_W / 2;
	localparam int ENTRY_F = ENTRY_W / 2;
	localparam int PROD_W  = COORD_W + ENTRY_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int QUO_W   = COORD_W + COORD_F;
	localparam int ROW_W   = 4 * ENTRY_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_EN = 3'd4;

	localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
	localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
	localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_0100_0000_0000;
	localparam logic [ROW_W-1:0] ROW3_RST = 64'h0100_0000_0000_0000;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
		coord_t in_w;
	} in_word_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		coord_t out_w;
		logic   w_zero;
		logic   saturated;
	} out_word_t;

	// Clamped row sums leaving the matrix stages.
	typedef struct packed {
		coord_t [3:0] r;
		logic         sat;
	} xf_res_t;

	// Quotients and side information leaving the divider.
	typedef struct packed {
		coord_t [3:0]               r;
		logic                       sat;
		logic                       wz;
		logic [2:0]                 neg;
		logic [2:0][QUO_W-1:0]      q;
	} dv_res_t;

endpackage

@@ src/vtpd_xform.sv @@
// ----------------------------------------------------------------------------
// Matrix stages
// Four-stage matrix times vector product with floor rounding and clamping.
// ----------------------------------------------------------------------------
module vtpd_xform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  vtpd_pkg::in_word_t                  in_data,
	input  logic [3:0][vtpd_pkg::ROW_W-1:0]     rows,
	input  logic                                div_en,
	output logic                                res_valid,
	output vtpd_pkg::xf_res_t                   res
);
	import vtpd_pkg::*;

	logic                          v_s1, v_s2, v_s3, v_s4;
	coord_t [3:0]                  vec_s1;
	logic signed [PROD_W-1:0]      prod_s2 [4][4];
	logic signed [SUM_W-1:0]       sum_s3 [4];
	xf_res_t                       res_s4;

	logic signed [PROD_W-1:0]      prod_d [4][4];
	logic signed [SUM_W-1:0]       sum_d [4];
	xf_res_t                       res_d;
	logic signed [SUM_W-1:0]       shf;
	logic signed [ENTRY_W-1:0]     ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Both operands are widened first so the product is formed at full width.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				ent = rows[i][ENTRY_W*j +: ENTRY_W];
				prod_d[i][j] = PROD_W'(ent) * PROD_W'(vec_s1[j]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_d[i] = SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1])
				+ SUM_W'(prod_s2[i][2]) + SUM_W'(prod_s2[i][3]);
		end
	end

	// The arithmetic shift is a floor; values that do not fit clamp to the rails.
	always_comb begin
		res_d.sat = 1'b0;
		shf = '0;
		for (int i = 0; i < 4; i++) begin
			shf = sum_s3[i] >>> ENTRY_F;
			if (&shf[SUM_W-1:COORD_W-1] || ~|shf[SUM_W-1:COORD_W-1]) begin
				res_d.r[i] = shf[COORD_W-1:0];
			end else begin
				res_d.sat = 1'b1;
				res_d.r[i] = shf[SUM_W-1] ? COORD_MIN : COORD_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= in_data.in_x;
			vec_s1[1] <= in_data.in_y;
			vec_s1[2] <= in_data.in_z;
			vec_s1[3] <= div_en ? coord_t'(1) <<< COORD_F : in_data.in_w;
			prod_s2 <= prod_d;
			sum_s3 <= sum_d;
			res_s4 <= res_d;
		end
	end

	assign res_valid = v_s4;
	assign res = res_s4;

endmodule

@@ src/vtpd_divider.sv @@
// ----------------------------------------------------------------------------
// Divider pipeline
// Three restoring dividers, one quotient bit per stage, sharing one divisor.
// ----------------------------------------------------------------------------
module vtpd_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 div_en,
	input  logic                 in_valid,
	input  vtpd_pkg::xf_res_t    in_res,
	output logic                 res_valid,
	output vtpd_pkg::dv_res_t    res
);
	import vtpd_pkg::*;

	localparam int NST = QUO_W;

	typedef struct packed {
		coord_t [3:0]               r;
		logic                       sat;
		logic                       wz;
		logic [2:0]                 neg;
		logic [2:0][COORD_W-1:0]    un;
		logic [COORD_W-1:0]         ud;
		logic [2:0][QUO_W-1:0]      q;
		logic [2:0][COORD_W-1:0]    rem;
	} dv_stage_t;

	logic [NST:0]  v_s;
	dv_stage_t     st_s [NST+1];
	dv_stage_t     nx [NST];
	dv_stage_t     prep;

	function automatic logic [COORD_W-1:0] mag(coord_t v);
		logic [COORD_W-1:0] u;
		u = v;
		return v[COORD_W-1] ? ~u + 1'b1 : u;
	endfunction

	always_comb begin
		prep = '0;
		prep.r = in_res.r;
		prep.sat = in_res.sat;
		prep.wz = div_en && (in_res.r[3] == '0);
		prep.ud = mag(in_res.r[3]);
		for (int k = 0; k < 3; k++) begin
			prep.neg[k] = in_res.r[k][COORD_W-1] ^ in_res.r[3][COORD_W-1];
			prep.un[k] = mag(in_res.r[k]);
		end
	end

	for (genvar t = 0; t < NST; t++) begin : g_step
		localparam int BI = NST - 1 - t;
		localparam int UB = (BI >= COORD_F) ? (BI - COORD_F) : 0;
		always_comb begin
			logic [COORD_W-1:0] remx;
			logic               bitv;
			nx[t] = st_s[t];
			for (int k = 0; k < 3; k++) begin
				if (BI >= COORD_F) begin
					bitv = st_s[t].un[k][UB];
				end else begin
					bitv = 1'b0;
				end
				remx = {st_s[t].rem[k][COORD_W-2:0], bitv};
				if (remx >= st_s[t].ud) begin
					nx[t].rem[k] = remx - st_s[t].ud;
					nx[t].q[k] = {st_s[t].q[k][QUO_W-2:0], 1'b1};
				end else begin
					nx[t].rem[k] = remx;
					nx[t].q[k] = {st_s[t].q[k][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep;
			for (int t = 0; t < NST; t++) begin
				st_s[t+1] <= nx[t];
			end
		end
	end

	assign res_valid = v_s[NST];
	assign res.r = st_s[NST].r;
	assign res.sat = st_s[NST].sat;
	assign res.wz = st_s[NST].wz;
	assign res.neg = st_s[NST].neg;
	assign res.q = st_s[NST].q;

endmodule

@@ src/vertex_transform_perspective_divide.sv @@
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Multiplies each vertex by a 4x4 Q8.8 matrix and optionally divides by w.
// ----------------------------------------------------------------------------
// The block takes one Q16.16 vertex word per cycle and returns one result word
// per vertex, in order. The path is a fixed pipeline: four matrix stages
// (operand register, sixteen multipliers, row adders, floor and clamp), one
// divider set-up stage, 48 divider stages that each resolve one quotient bit
// for x, y and z against the shared w, and an output register that applies
// sign, saturation and the divide-mode selection. A new word is taken every
// cycle while the output is not stalled. The whole pipeline advances together
// whenever the output register is empty or being read, so a stall at the
// output holds every stage without loss. Matrix rows and divide mode are
// written through the configuration port, which is always ready; they must be
// written only while no vertex is in flight. Reset loads the identity matrix
// with divide mode on.
module vertex_transform_perspective_divide (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  vtpd_pkg::in_word_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output vtpd_pkg::out_word_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vtpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vtpd_pkg::ROW_W-1:0]        cfg_data
);
	import vtpd_pkg::*;

	logic [3:0][ROW_W-1:0] rows_q;
	logic                  div_en_q;
	logic                  adv;
	logic                  xf_valid, dv_valid;
	xf_res_t               xf_res;
	dv_res_t               dv_res;
	logic                  out_valid_q;
	out_word_t             out_q;
	out_word_t             out_d;

	// Configuration registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW0_RST;
			rows_q[1] <= ROW1_RST;
			rows_q[2] <= ROW2_RST;
			rows_q[3] <= ROW3_RST;
			div_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0:   rows_q[0] <= cfg_data;
				REG_ROW1:   rows_q[1] <= cfg_data;
				REG_ROW2:   rows_q[2] <= cfg_data;
				REG_ROW3:   rows_q[3] <= cfg_data;
				REG_DIV_EN: div_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the output register can take a new word.
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	vtpd_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.rows     (rows_q),
		.div_en   (div_en_q),
		.res_valid(xf_valid),
		.res      (xf_res)
	);

	vtpd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.div_en   (div_en_q),
		.in_valid (xf_valid),
		.in_res   (xf_res),
		.res_valid(dv_valid),
		.res      (dv_res)
	);

	// Final selection. A quotient beyond the signed range clamps; with a zero w
	// each numerator goes to the rail of its own sign, or stays at zero.
	always_comb begin
		coord_t [2:0]       v;
		logic               sat;
		logic [QUO_W-1:0]   lim;
		sat = dv_res.sat;
		for (int k = 0; k < 3; k++) begin
			lim = QUO_W'(COORD_MAX) + QUO_W'(dv_res.neg[k]);
			if (!div_en_q) begin
				v[k] = dv_res.r[k];
			end else if (dv_res.wz) begin
				if (dv_res.r[k] == '0) begin
					v[k] = '0;
				end else begin
					sat = 1'b1;
					v[k] = dv_res.r[k][COORD_W-1] ? COORD_MIN : COORD_MAX;
				end
			end else if (dv_res.q[k] > lim) begin
				sat = 1'b1;
				v[k] = dv_res.neg[k] ? COORD_MIN : COORD_MAX;
			end else if (dv_res.neg[k]) begin
				v[k] = coord_t'(~dv_res.q[k][COORD_W-1:0] + 1'b1);
			end else begin
				v[k] = dv_res.q[k][COORD_W-1:0];
			end
		end
		out_d.out_x = v[0];
		out_d.out_y = v[1];
		out_d.out_z = v[2];
		out_d.out_w = dv_res.r[3];
		out_d.w_zero = dv_res.wz;
		out_d.saturated = sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
